@@ hdl/fsd_pkg.sv @@
// Shared constants and types for the sum-checked frame deframer.
`default_nettype none
package fsd_pkg;

  localparam int MAX_FRAME_DEF = 64;

  localparam logic [7:0] HEAD_BYTE = 8'h68;
  localparam logic [7:0] TAIL_BYTE = 8'h16;
  localparam logic [7:0] MIN_FRAME = 8'd7;

  // Commands from the sequencer to the byte store.
  typedef struct packed {
    logic wr;
    logic drop;
  } fsd_store_cmd_t;

endpackage
`default_nettype wire

@@ hdl/fsd_in_if.sv @@
// Valid/ready channel that carries one received byte.
`default_nettype none
interface fsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ hdl/fsd_out_if.sv @@
// Valid/ready channel that carries one payload result of an accepted frame.
`default_nettype none
interface fsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] dev_addr;
  logic [7:0] func_code;
  logic [7:0] sub_code;
  logic [5:0] payload_count;
  logic [5:0] payload_index;
  logic [7:0] payload_byte;
  logic       last_of_frame;

  modport source (output valid, output dev_addr, output func_code, output sub_code,
                  output payload_count, output payload_index, output payload_byte,
                  output last_of_frame, input ready);
  modport sink (input valid, input dev_addr, input func_code, input sub_code,
                input payload_count, input payload_index, input payload_byte,
                input last_of_frame, output ready);
endinterface
`default_nettype wire

@@ hdl/fsd_store.sv @@
// Circular byte store with head pointer, fill count and one registered read port.
`default_nettype none
module fsd_store #(
  parameter int MAX_FRAME = fsd_pkg::MAX_FRAME_DEF,
  localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1,
  localparam int CW = $clog2(MAX_FRAME + 1)
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire fsd_pkg::fsd_store_cmd_t cmd,
  input  wire logic [7:0]             wr_byte,
  input  wire logic [CW-1:0]          drop_n,
  input  wire logic [AW-1:0]          rd_off,
  output logic [7:0]                  rd_data,
  output logic [CW-1:0]               fill
);
  import fsd_pkg::*;

  localparam logic [AW:0] DEPTH = (AW + 1)'(MAX_FRAME);

  logic [7:0]    mem [MAX_FRAME];
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  // Both operands are at most the depth, so one conditional subtract wraps the sum.
  function automatic logic [AW-1:0] wrap_idx(input logic [AW:0] s);
    logic [AW:0] r;
    r = (s >= DEPTH) ? (s - DEPTH) : s;
    return r[AW-1:0];
  endfunction

  assign raddr = wrap_idx({1'b0, head_r} + (AW + 1)'(rd_off));
  assign fill  = fill_r;

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    waddr    = wrap_idx({1'b0, head_r} + (AW + 1)'(fill_r));
    if (cmd.wr) begin
      if (fill_r == CW'(MAX_FRAME)) begin
        // Store full: the new byte overwrites the oldest one.
        waddr    = head_r;
        head_nxt = wrap_idx({1'b0, head_r} + (AW + 1)'(1));
      end else begin
        fill_nxt = fill_r + CW'(1);
      end
    end else if (cmd.drop) begin
      head_nxt = wrap_idx({1'b0, head_r} + (AW + 1)'(drop_n));
      fill_nxt = fill_r - drop_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[waddr] <= wr_byte;
    end
    rd_data <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/sum_checked_frame_deframer.sv @@
// Top level: byte store plus the scan sequencer that checks and emits frames.
// Each received byte is written to a circular store, and the store is then scanned from its
// oldest byte for a 0x68 header with a length of 7 to MAX_FRAME, a 0x16 tail and a matching
// 8-bit sum. Everything goes through the store's single registered read port: each byte read
// passes through the fetch state before its value is used. At each position the scan reads
// the header byte, then the length byte, then the tail byte, and then sums the frame bytes
// one by one up to the checksum compare, moving on by one byte when a check fails.
// An accepted frame then fetches its three header fields and gives one result per payload
// byte, or one result for an empty payload, each held until out_ready takes it.
// The input is not ready until the scan of the previous byte has finished.
// No clearing pass is needed after reset: only bytes below the fill count are ever read.
`default_nettype none
module sum_checked_frame_deframer #(
  parameter int MAX_FRAME = fsd_pkg::MAX_FRAME_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  fsd_in_if.sink      in_ch,
  fsd_out_if.source   out_ch
);
  import fsd_pkg::*;

  localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam logic [8:0] MAX_LEN = 9'(MAX_FRAME);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_SCAN  = 12'b0000_0000_0010,
    ST_FETCH = 12'b0000_0000_0100,
    ST_HEAD  = 12'b0000_0000_1000,
    ST_LEN   = 12'b0000_0001_0000,
    ST_TAIL  = 12'b0000_0010_0000,
    ST_SUM   = 12'b0000_0100_0000,
    ST_CSUM  = 12'b0000_1000_0000,
    ST_HDR   = 12'b0001_0000_0000,
    ST_LOAD  = 12'b0010_0000_0000,
    ST_EMIT  = 12'b0100_0000_0000,
    ST_DROP  = 12'b1000_0000_0000
  } state_t;

  state_t         state_r, state_nxt;
  state_t         ret_r, ret_nxt;
  logic [CW-1:0]  pos_r, pos_nxt;
  logic [AW-1:0]  off_r, off_nxt;
  logic [7:0]     cnt_r, cnt_nxt;
  logic [7:0]     len_r, len_nxt;
  logic [7:0]     sum_r, sum_nxt;
  logic [7:0]     addr_r, addr_nxt;
  logic [7:0]     func_r, func_nxt;
  logic [7:0]     sub_r, sub_nxt;
  logic [7:0]     byte_r, byte_nxt;
  logic           last_r, last_nxt;

  fsd_store_cmd_t cmd;
  logic [7:0]     rd_data;
  logic [CW-1:0]  fill;
  logic [CW-1:0]  rem;
  logic           in_fire;
  logic           out_fire;

  fsd_store #(.MAX_FRAME(MAX_FRAME)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .wr_byte (in_ch.rx_byte),
    .drop_n  (pos_r),
    .rd_off  (off_r),
    .rd_data (rd_data),
    .fill    (fill)
  );

  // Offsets into the store stay below the fill count, so the low bits suffice.
  function automatic logic [AW-1:0] off_of(input logic [8:0] s);
    return s[AW-1:0];
  endfunction

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;
  assign rem         = fill - pos_r;

  assign cmd.wr   = in_fire;
  assign cmd.drop = (state_r == ST_DROP);

  assign out_ch.valid         = (state_r == ST_EMIT);
  assign out_ch.dev_addr      = addr_r;
  assign out_ch.func_code     = func_r;
  assign out_ch.sub_code      = sub_r;
  assign out_ch.payload_count = 6'(len_r - MIN_FRAME);
  assign out_ch.payload_index = cnt_r[5:0];
  assign out_ch.payload_byte  = byte_r;
  assign out_ch.last_of_frame = last_r;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    pos_nxt   = pos_r;
    off_nxt   = off_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    addr_nxt  = addr_r;
    func_nxt  = func_r;
    sub_nxt   = sub_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          pos_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (9'(rem) < {1'b0, MIN_FRAME}) begin
          state_nxt = ST_DROP;
        end else begin
          off_nxt   = off_of(9'(pos_r));
          ret_nxt   = ST_HEAD;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ret_r;
      end
      ST_HEAD: begin
        if (rd_data != HEAD_BYTE) begin
          pos_nxt   = pos_r + CW'(1);
          state_nxt = ST_SCAN;
        end else begin
          off_nxt   = off_of(9'(pos_r) + 9'd1);
          ret_nxt   = ST_LEN;
          state_nxt = ST_FETCH;
        end
      end
      ST_LEN: begin
        len_nxt = rd_data;
        if (rd_data < MIN_FRAME || {1'b0, rd_data} > MAX_LEN) begin
          pos_nxt   = pos_r + CW'(1);
          state_nxt = ST_SCAN;
        end else if (9'(rem) < {1'b0, rd_data}) begin
          // The candidate is still incomplete; keep it for later bytes.
          state_nxt = ST_DROP;
        end else begin
          off_nxt   = off_of(9'(pos_r) + {1'b0, rd_data} - 9'd1);
          ret_nxt   = ST_TAIL;
          state_nxt = ST_FETCH;
        end
      end
      ST_TAIL: begin
        if (rd_data != TAIL_BYTE) begin
          pos_nxt   = pos_r + CW'(1);
          state_nxt = ST_SCAN;
        end else begin
          cnt_nxt   = '0;
          sum_nxt   = '0;
          off_nxt   = off_of(9'(pos_r));
          ret_nxt   = ST_SUM;
          state_nxt = ST_FETCH;
        end
      end
      ST_SUM: begin
        sum_nxt   = sum_r + rd_data;
        cnt_nxt   = cnt_r + 8'd1;
        state_nxt = ST_FETCH;
        if (cnt_r == len_r - 8'd3) begin
          off_nxt = off_of(9'(pos_r) + {1'b0, len_r} - 9'd2);
          ret_nxt = ST_CSUM;
        end else begin
          off_nxt = off_of(9'(pos_r) + {1'b0, cnt_r} + 9'd1);
          ret_nxt = ST_SUM;
        end
      end
      ST_CSUM: begin
        if (rd_data != sum_r) begin
          pos_nxt   = pos_r + CW'(1);
          state_nxt = ST_SCAN;
        end else begin
          cnt_nxt   = '0;
          off_nxt   = off_of(9'(pos_r) + 9'd2);
          ret_nxt   = ST_HDR;
          state_nxt = ST_FETCH;
        end
      end
      ST_HDR: begin
        case (cnt_r[1:0])
          2'd0:    addr_nxt = rd_data;
          2'd1:    func_nxt = rd_data;
          default: sub_nxt  = rd_data;
        endcase
        if (cnt_r == 8'd2) begin
          cnt_nxt = '0;
          if (len_r == MIN_FRAME) begin
            // A frame without payload still gives one result.
            byte_nxt  = '0;
            last_nxt  = 1'b1;
            state_nxt = ST_EMIT;
          end else begin
            off_nxt   = off_of(9'(pos_r) + 9'd5);
            ret_nxt   = ST_LOAD;
            state_nxt = ST_FETCH;
          end
        end else begin
          cnt_nxt   = cnt_r + 8'd1;
          off_nxt   = off_of(9'(pos_r) + {1'b0, cnt_r} + 9'd3);
          ret_nxt   = ST_HDR;
          state_nxt = ST_FETCH;
        end
      end
      ST_LOAD: begin
        byte_nxt  = rd_data;
        last_nxt  = (cnt_r == len_r - 8'd8);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_fire) begin
          if (last_r) begin
            pos_nxt   = CW'(9'(pos_r) + {1'b0, len_r});
            state_nxt = ST_DROP;
          end else begin
            cnt_nxt   = cnt_r + 8'd1;
            off_nxt   = off_of(9'(pos_r) + {1'b0, cnt_r} + 9'd6);
            ret_nxt   = ST_LOAD;
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_DROP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      pos_r   <= '0;
      off_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      pos_r   <= pos_nxt;
      off_r   <= off_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    sum_r  <= sum_nxt;
    addr_r <= addr_nxt;
    func_r <= func_nxt;
    sub_r  <= sub_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input ready while a result is pending");

  a_last_drops: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_ch.last_of_frame |=> state_r == ST_DROP)
    else $error("final result of a frame not followed by the store drop");

  a_pos_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> pos_r <= fill)
    else $error("scan position beyond the held bytes");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= CW'(MAX_FRAME))
    else $error("fill count beyond the store depth");

endmodule
`default_nettype wire

@@ tb/deframe_checker.sv @@
// Checker for the sum-checked frame deframer: predicts payload results and compares them.
`timescale 1ns / 1ps
module deframe_checker (
  input  wire clk,
  input  wire rst_n,
  fsd_in_if   in_ch,
  fsd_out_if  out_ch,
  output int  mismatches,
  output int  awaited
);
  import fsd_pkg::*;

  typedef struct packed {
    logic [7:0] dev_addr;
    logic [7:0] func_code;
    logic [7:0] sub_code;
    logic [5:0] payload_count;
    logic [5:0] payload_index;
    logic [7:0] payload_byte;
    logic       last_of_frame;
  } payload_rec_t;

  logic [7:0]   held_bytes[$];   // bytes still held by the deframer, oldest first
  payload_rec_t payload_due[$];  // payload results owed by accepted frames
  payload_rec_t want;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] deframer mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s is 0x%02h, 0x%02h was due", name, got, exp_val));
  endtask

  // Takes one received byte and scans the held bytes for at most one good frame.
  function automatic void deframe_byte(input logic [7:0] b);
    int pos;
    int rem;
    int len;
    int count;
    int n;
    int k;
    int i;
    bit stop;
    logic [7:0] csum;
    payload_rec_t r;
    if (held_bytes.size() >= MAX_FRAME_DEF) void'(held_bytes.pop_front());
    held_bytes.push_back(b);
    pos = 0;
    stop = 1'b0;
    while (!stop && pos < held_bytes.size()) begin
      rem = held_bytes.size() - pos;
      if (rem < MIN_FRAME) begin
        stop = 1'b1;
      end else if (held_bytes[pos] != HEAD_BYTE) begin
        pos++;
      end else begin
        len = held_bytes[pos + 1];
        if (len < MIN_FRAME || len > MAX_FRAME_DEF) begin
          pos++;
        end else if (rem < len) begin
          // Candidate still arriving: keep everything from its header on.
          stop = 1'b1;
        end else begin
          csum = '0;
          for (i = 0; i < len - 2; i++) csum += held_bytes[pos + i];
          if (held_bytes[pos + len - 1] == TAIL_BYTE && csum == held_bytes[pos + len - 2]) begin
            count = len - MIN_FRAME;
            n = (count != 0) ? count : 1;
            for (k = 0; k < n; k++) begin
              r.dev_addr      = held_bytes[pos + 2];
              r.func_code     = held_bytes[pos + 3];
              r.sub_code      = held_bytes[pos + 4];
              r.payload_count = 6'(count);
              r.payload_index = 6'(k);
              r.payload_byte  = (count != 0) ? held_bytes[pos + 5 + k] : 8'h00;
              r.last_of_frame = (k + 1 == n);
              payload_due.push_back(r);
            end
            pos += len;
            stop = 1'b1;
          end else begin
            // Rejected candidate: resume right after its header byte.
            pos++;
          end
        end
      end
    end
    repeat (pos) void'(held_bytes.pop_front());
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      held_bytes.delete();
      payload_due.delete();
    end else begin
      // Results are checked before the byte of this edge is absorbed, since a byte
      // cannot produce a result in the same cycle it is transferred.
      if (out_ch.valid && out_ch.ready) begin
        if (payload_due.size() == 0) begin
          report_mismatch("payload result with no accepted frame behind it");
        end else begin
          want = payload_due.pop_front();
          check_field("dev_addr", out_ch.dev_addr, want.dev_addr);
          check_field("func_code", out_ch.func_code, want.func_code);
          check_field("sub_code", out_ch.sub_code, want.sub_code);
          check_field("payload_count", 8'(out_ch.payload_count), 8'(want.payload_count));
          check_field("payload_index", 8'(out_ch.payload_index), 8'(want.payload_index));
          check_field("payload_byte", out_ch.payload_byte, want.payload_byte);
          check_field("last_of_frame", 8'(out_ch.last_of_frame), 8'(want.last_of_frame));
        end
      end
      if (in_ch.valid && in_ch.ready) deframe_byte(in_ch.rx_byte);
    end
    awaited = payload_due.size();
  end

endmodule

@@ tb/testbench.sv @@
// Top of the deframer testbench: clock, reset, byte stimulus, output pacing and verdict.
`timescale 1ns / 1ps
module testbench;
  import fsd_pkg::*;

  localparam int RANDOM_BYTES    = 333;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int QUIET_LIMIT     = 20000;
  localparam int SETTLE_CYCLES   = 300;

  typedef logic [7:0] byte_q_t[$];
  typedef enum {FLAW_NONE, FLAW_SUM, FLAW_TAIL, FLAW_CUT} frame_flaw_t;

  logic clk = 1'b0;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;
  bit   hold_off_req;
  bit   hold_off_used;
  int   hold_left;
  int   bytes_sent;
  int   quiet_cycles;
  int   mismatches;
  int   awaited;

  fsd_in_if  in_ch();
  fsd_out_if out_ch();

  sum_checked_frame_deframer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deframe_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always #1 clk = ~clk;

  // Result side: random back-pressure, plus one long hold-off once it is requested.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_off_req && !hold_off_used) begin
      hold_off_used <= 1'b1;
      hold_left <= HOLD_OFF_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic byte_q_t make_frame(input logic [7:0] addr, input logic [7:0] func,
                                         input logic [7:0] sub, input int count,
                                         input frame_flaw_t flaw);
    byte_q_t f;
    logic [7:0] csum;
    f = {HEAD_BYTE, 8'(count + 7), addr, func, sub};
    repeat (count) f.push_back(8'($urandom));
    csum = '0;
    foreach (f[k]) csum += f[k];
    if (flaw == FLAW_SUM) csum += 8'($urandom_range(1, 255));
    f.push_back(csum);
    f.push_back((flaw == FLAW_TAIL) ? (TAIL_BYTE ^ 8'($urandom_range(1, 255))) : TAIL_BYTE);
    if (flaw == FLAW_CUT) repeat ($urandom_range(1, f.size() - 2)) void'(f.pop_back());
    return f;
  endfunction

  // One random stretch of line traffic: mostly good frames, some broken ones and noise.
  function automatic byte_q_t make_traffic();
    byte_q_t bq;
    int pick;
    int count;
    pick = $urandom_range(99);
    if (pick < 80) count = $urandom_range(0, 6);
    else if (pick < 95) count = $urandom_range(7, 20);
    else count = $urandom_range(21, MAX_FRAME_DEF - 7);
    pick = $urandom_range(99);
    if (pick < 65) begin
      bq = make_frame(8'($urandom), 8'($urandom), 8'($urandom), count, FLAW_NONE);
    end else if (pick < 77) begin
      bq = make_frame(8'($urandom), 8'($urandom), 8'($urandom), count % 12,
                      frame_flaw_t'($urandom_range(1, 3)));
    end else if (pick < 92) begin
      repeat ($urandom_range(1, 4)) bq.push_back(8'($urandom));
    end else begin
      bq.push_back(HEAD_BYTE);
      bq.push_back($urandom_range(1) ? 8'($urandom_range(0, 6))
                                     : 8'($urandom_range(MAX_FRAME_DEF + 1, 255)));
    end
    return bq;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_rx(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_bytes(input byte_q_t bq);
    foreach (bq[k]) send_rx(bq[k]);
  endtask

  initial begin
    int phase;
    int target;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    tx_idle_pct = 32;
    rx_idle_pct = 75;
    hold_off_req = 1'b0;
    hold_off_used = 1'b0;
    bytes_sent = 0;
    quiet_cycles = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A stray byte, an empty-payload frame with extreme header fields, headers with a
    // length too short and too long, then frames failing on checksum and on tail.
    send_rx(8'h00);
    send_bytes(make_frame(8'hFF, 8'h00, 8'hFF, 0, FLAW_NONE));
    send_bytes({HEAD_BYTE, 8'h06, HEAD_BYTE, 8'h41});
    send_bytes(make_frame(8'h00, 8'hFF, 8'h00, 0, FLAW_SUM));
    send_bytes(make_frame(8'h5A, 8'hA5, 8'h3C, 1, FLAW_TAIL));

    target = bytes_sent;
    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct <= (phase == 0) ? 32 : (phase == 1) ? 75 : 0;
      rx_idle_pct <= (phase == 0) ? 75 : (phase == 1) ? 32 : 0;
      // In the last phase the sender is never idle and the result side gets one long stall.
      if (phase == 2) hold_off_req <= 1'b1;
      target += RANDOM_BYTES / 3;
      while (bytes_sent < target) send_bytes(make_traffic());
    end
    in_ch.valid <= 1'b0;

    while (awaited != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/fsd_pkg.sv
hdl/fsd_in_if.sv
hdl/fsd_out_if.sv
hdl/fsd_store.sv
hdl/sum_checked_frame_deframer.sv
tb/deframe_checker.sv
tb/testbench.sv
